[rtl/fwd2u_pkg.sv]
package fwd2u_pkg;

  // Most digits a field may hold, and the highest column index.
  localparam int MAX_DIGITS = 20;
  localparam logic [4:0] TOP_COL = 5'(MAX_DIGITS - 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [4:0]  DIGIT_COUNT_RST = 5'd20;
  localparam logic [63:0] UPPER_BOUND_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LOWER_BOUND_RST = 64'h0;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef struct packed {
    logic [4:0]  digit_count;
    logic [63:0] upper_bound;
    logic [63:0] lower_bound;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       prior_error;
  } item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [4:0]  consumed;
    logic        error;
  } res_t;

  // Power of ten for a column, units column is 0.
  function automatic logic [63:0] pow_ten(input logic [4:0] col);
    logic [63:0] p;
    case (col)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

  // Digit times a column weight as a short shift-and-add, truncated to 64 bits.
  function automatic logic [63:0] weight(input logic [63:0] p, input logic [3:0] dig);
    logic [63:0] w;
    w = (dig[0] ? p : 64'd0)
      + (dig[1] ? (p << 1) : 64'd0)
      + (dig[2] ? (p << 2) : 64'd0)
      + (dig[3] ? (p << 3) : 64'd0);
    return w;
  endfunction

endpackage

[rtl/fwd2u_cfg.sv]
module fwd2u_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fwd2u_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_wdata,
  output fwd2u_pkg::cfg_t                 cfg
);
  import fwd2u_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.digit_count <= DIGIT_COUNT_RST;
      cfg_r.upper_bound <= UPPER_BOUND_RST;
      cfg_r.lower_bound <= LOWER_BOUND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIGIT_COUNT: cfg_r.digit_count <= cfg_wdata[4:0];
        REG_UPPER_BOUND: cfg_r.upper_bound <= cfg_wdata;
        REG_LOWER_BOUND: cfg_r.lower_bound <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/fwd2u_in_reg.sv]
module fwd2u_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fwd2u_pkg::item_t in_item,
  input  logic             take,
  output logic             s1_valid,
  output fwd2u_pkg::item_t s1_item
);
  import fwd2u_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  // The held word leaves when the step logic takes it; a new one may enter
  // in the same cycle.
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

[rtl/fwd2u_step.sv]
module fwd2u_step (
  input  logic             clk,
  input  logic             rst_n,
  input  fwd2u_pkg::cfg_t  cfg,
  input  logic             s1_valid,
  input  fwd2u_pkg::item_t s1_item,
  input  logic             out_free,
  output logic             take,
  output logic             res_valid,
  output fwd2u_pkg::res_t  res
);
  import fwd2u_pkg::*;

  logic [4:0]  pos_r,     pos_nxt;
  logic [63:0] running_r, running_nxt;
  logic [63:0] headroom_r, headroom_nxt;
  logic        ferr_r,    ferr_nxt;

  logic        bad_count;
  logic        first;
  logic        last;
  logic        produces;
  logic [4:0]  col;
  logic [63:0] hv;
  logic [63:0] rv;
  logic        fe;
  logic        is_digit;
  logic [3:0]  dig;
  logic [63:0] t;
  logic [64:0] diff;
  logic        digit_err;
  logic        err;
  logic [63:0] rv_new;
  logic        final_err;

  always_comb begin
    bad_count = (cfg.digit_count == 5'd0) || (cfg.digit_count > 5'(MAX_DIGITS));
    first     = (pos_r == 5'd0);
    last      = ({1'b0, pos_r} + 6'd1) >= {1'b0, cfg.digit_count};
    col       = last ? 5'd0 : 5'(cfg.digit_count - 5'd1 - pos_r);
    if (col > TOP_COL) begin
      col = TOP_COL;
    end
    produces  = bad_count || last;
    take      = s1_valid && (!produces || out_free);

    // A field's first byte reloads the headroom and samples the upstream error.
    hv = first ? cfg.upper_bound : headroom_r;
    rv = first ? 64'd0 : running_r;
    fe = first ? s1_item.prior_error : ferr_r;

    is_digit  = (s1_item.char_byte >= CHAR_ZERO) && (s1_item.char_byte <= CHAR_NINE);
    dig       = s1_item.char_byte[3:0];
    t         = weight(pow_ten(col), dig);
    diff      = {1'b0, hv} - {1'b0, t};
    digit_err = !is_digit || ((col == TOP_COL) && (dig > 4'd1)) || diff[64];
    err       = fe || digit_err;
    rv_new    = err ? rv : (rv + t);

    final_err = err || (rv_new < cfg.lower_bound);

    pos_nxt      = pos_r;
    running_nxt  = running_r;
    headroom_nxt = headroom_r;
    ferr_nxt     = ferr_r;
    res_valid    = 1'b0;
    res          = '0;
    res.error    = 1'b1;
    if (take) begin
      if (bad_count) begin
        pos_nxt      = 5'd0;
        running_nxt  = 64'd0;
        headroom_nxt = 64'd0;
        ferr_nxt     = 1'b0;
        res_valid    = 1'b1;
      end else begin
        running_nxt  = rv_new;
        headroom_nxt = err ? hv : diff[63:0];
        ferr_nxt     = last ? final_err : err;
        pos_nxt      = last ? 5'd0 : (pos_r + 5'd1);
        if (last) begin
          res_valid = 1'b1;
          if (!final_err) begin
            res.value    = rv_new;
            res.consumed = cfg.digit_count;
            res.error    = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 5'd0;
      running_r  <= 64'd0;
      headroom_r <= 64'd0;
      ferr_r     <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      running_r  <= running_nxt;
      headroom_r <= headroom_nxt;
      ferr_r     <= ferr_nxt;
    end
  end

  // The column counter never runs past the widest field.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= TOP_COL)
    else $error("digit position out of range");

  // A byte that ends no field moves the position on by exactly one.
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !produces) |=> (pos_r == $past(pos_r) + 5'd1))
    else $error("digit position did not advance");

  // Any emitted word leaves the next byte at the start of a field.
  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (pos_r == 5'd0))
    else $error("field did not restart after a result");

  // A clean result always reports the full configured width.
  a_clean_count: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.error) |-> (res.consumed == cfg.digit_count && !bad_count))
    else $error("clean result with wrong character count");

endmodule

[rtl/fwd2u_out_reg.sv]
module fwd2u_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  input  fwd2u_pkg::res_t res,
  output logic            out_free,
  output logic            out_valid,
  input  logic            out_stall,
  output fwd2u_pkg::res_t out_res
);
  import fwd2u_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

  // A new word is only loaded into a slot that is empty or being taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free)
    else $error("result word overwritten while stalled");

endmodule

[rtl/fixed_width_decimal_to_u64.sv]
// Fixed-width ASCII decimal to 64-bit unsigned converter. Characters arrive one
// word per cycle while in_stall is low, most significant digit first, in fields
// of digit_count bytes. Each byte passes an input register and then one step of
// combinational logic (weight lookup, headroom subtract, value add, lower-bound
// compare) that updates the field state and, at a field's last byte, loads one
// result word into the output register. A byte is taken every cycle while
// results are being drained, so the sustained rate is one byte per cycle. The
// output register decouples the two sides: while a result waits for out_stall
// to drop, bytes that do not end a field still flow through. Any non-digit
// byte, a digit that would push the value past upper_bound, or a final value
// below lower_bound yields error with value and consumed both zero; a
// prior_error seen with a field's first byte does the same. A digit_count of
// zero or above twenty turns every byte into an error word of its own.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// do so only while the block is idle, which the block does not enforce.
// upper_bound takes effect at a field's first byte, lower_bound at its last.
module fixed_width_decimal_to_u64 (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fwd2u_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_char_byte,
  input  logic                            in_prior_error,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [63:0]                     out_value,
  output logic [4:0]                      out_consumed,
  output logic                            out_error
);
  import fwd2u_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  take;
  logic  out_free;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  assign in_item.char_byte   = in_char_byte;
  assign in_item.prior_error = in_prior_error;

  fwd2u_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fwd2u_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  fwd2u_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .out_free  (out_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  fwd2u_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_value    = out_res.value;
  assign out_consumed = out_res.consumed;
  assign out_error    = out_res.error;

  // The input side only holds off while a byte is waiting in the input register.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

endmodule
